/* design/event_octant_activity_tracker_defines.svh */
// Assertion macros for the event octant activity tracker checker.
// Expects clk and arst_n in the scope of each use.
`ifndef EVENT_OCTANT_ACTIVITY_TRACKER_DEFINES_SVH
`define EVENT_OCTANT_ACTIVITY_TRACKER_DEFINES_SVH

// same-cycle implication
`define EOAT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EOAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/eoat_pkg.sv */
// Shared constants, codes and control types of the octant activity tracker.
// No dependencies.
`default_nettype none

package eoat_pkg;

	localparam int unsigned BATCH_LEN_DEF = 4;
	localparam int unsigned WEDGES        = 8;
	localparam int unsigned WEDGE_W       = 3;
	localparam int unsigned COORD_W       = 7;
	localparam int unsigned ACT_W         = 8;
	localparam int unsigned RAD_W         = 5;
	localparam int unsigned SHIFT_W       = 3;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned CFG_DATA_W    = 8;

	localparam logic [COORD_W-1:0] CENTER_X_RST = 7'd63;
	localparam logic [COORD_W-1:0] CENTER_Y_RST = 7'd56;
	localparam logic [ACT_W-1:0]   STEP_RST     = 8'd24;
	localparam logic [SHIFT_W-1:0] DECAY_RST    = 3'd2;
	localparam logic [ACT_W-1:0]   THRESH_RST   = 8'd64;

	localparam logic [ACT_W-1:0] ACT_CAP = 8'hFF;
	localparam logic [RAD_W-1:0] RAD_CAP = 5'd31;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X       = 3'd0,
		CFG_CENTER_Y       = 3'd1,
		CFG_STEP_SIZE      = 3'd2,
		CFG_DECAY_SHIFT    = 3'd3,
		CFG_EMIT_THRESHOLD = 3'd4
	} cfg_idx_t;

	localparam logic [WEDGE_W-1:0] WEDGE_E    = 3'd0;
	localparam logic [WEDGE_W-1:0] WEDGE_NE   = 3'd1;
	localparam logic [WEDGE_W-1:0] WEDGE_N    = 3'd2;
	localparam logic [WEDGE_W-1:0] WEDGE_NW   = 3'd3;
	localparam logic [WEDGE_W-1:0] WEDGE_WEST = 3'd4;
	localparam logic [WEDGE_W-1:0] WEDGE_SW   = 3'd5;
	localparam logic [WEDGE_W-1:0] WEDGE_S    = 3'd6;
	localparam logic [WEDGE_W-1:0] WEDGE_SE   = 3'd7;

	typedef struct packed {
		logic upd;
		logic leak;
		logic pick;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

/* design/eoat_if.sv */
// Valid/ready channel interfaces: event words in, result words out.
// Depends on eoat_pkg.
`default_nettype none

interface eoat_evt_if;
	logic                           valid;
	logic                           ready;
	logic [eoat_pkg::COORD_W-1:0]   x_pos;
	logic [eoat_pkg::COORD_W-1:0]   y_pos;
	logic                           polarity;

	modport source(output valid, output x_pos, output y_pos, output polarity, input ready);
	modport sink(input valid, input x_pos, input y_pos, input polarity, output ready);
endinterface

interface eoat_res_if;
	logic                           valid;
	logic                           ready;
	logic [eoat_pkg::WEDGE_W-1:0]   octant;
	logic [eoat_pkg::RAD_W-1:0]     radius;
	logic                           ping_polarity;
	logic [eoat_pkg::RAD_W-1:0]     strength;
	logic                           peak_flag;

	modport source(output valid, output octant, output radius, output ping_polarity,
		output strength, output peak_flag, input ready);
	modport sink(input valid, input octant, input radius, input ping_polarity,
		input strength, input peak_flag, output ready);
endinterface

`default_nettype wire

/* design/eoat_ctrl.sv */
// Controller: sequences event update, batch leak and dominant-wedge pick.
// Depends on eoat_pkg.
`default_nettype none

module eoat_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           evt_valid,
	output logic                evt_ready,
	input  wire eoat_pkg::stat_t stat,
	output eoat_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEAK,
		ST_PICK
	} state_t;

	state_t state_q;
	logic   ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (evt_valid && ready_q && stat.last) begin
						state_q <= ST_LEAK;
						ready_q <= 1'b0;
					end
				end
				ST_LEAK: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	assign evt_ready = ready_q;
	assign cmd.upd   = evt_valid & ready_q;
	assign cmd.leak  = (state_q == ST_LEAK);
	assign cmd.pick  = (state_q == ST_PICK) & stat.out_free;

endmodule

`default_nettype wire

/* design/eoat_dp.sv */
// Datapath: config registers, per-wedge stores, leak, argmax tree, result register.
// Depends on eoat_pkg; driven by eoat_ctrl commands.
`default_nettype none

module eoat_dp #(
	parameter int unsigned BATCH_LEN = eoat_pkg::BATCH_LEN_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire eoat_pkg::cmd_t                     cmd,
	output eoat_pkg::stat_t                         stat,
	input  wire logic                               cfg_we,
	input  wire logic [eoat_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [eoat_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic [eoat_pkg::COORD_W-1:0]       x_pos,
	input  wire logic [eoat_pkg::COORD_W-1:0]       y_pos,
	input  wire logic                               polarity,
	output logic                                    res_valid,
	input  wire logic                               res_ready,
	output logic [eoat_pkg::WEDGE_W-1:0]            res_octant,
	output logic [eoat_pkg::RAD_W-1:0]              res_radius,
	output logic                                    res_ping_polarity,
	output logic [eoat_pkg::RAD_W-1:0]              res_strength,
	output logic                                    res_peak_flag
);

	localparam int unsigned POS_W = (BATCH_LEN > 1) ? $clog2(BATCH_LEN) : 1;
	localparam int unsigned CNT_W = $clog2(BATCH_LEN + 1);
	localparam int unsigned SUM_W = $clog2(31 * BATCH_LEN + 1);
	localparam int unsigned CW    = eoat_pkg::COORD_W;
	localparam int unsigned AW    = eoat_pkg::ACT_W;
	localparam int unsigned NW    = eoat_pkg::WEDGES;

	typedef struct packed {
		logic [eoat_pkg::WEDGE_W-1:0] idx;
		logic [AW-1:0]                act;
		logic [SUM_W-1:0]             sum;
		logic [CNT_W-1:0]             cnt;
		logic                         pol;
	} cand_t;

	function automatic cand_t pick_c(input cand_t a, input cand_t b);
		pick_c = (a.act >= b.act) ? a : b;
	endfunction

	// configuration
	logic [CW-1:0]                     center_x_q;
	logic [CW-1:0]                     center_y_q;
	logic [AW-1:0]                     step_q;
	logic [eoat_pkg::SHIFT_W-1:0]      decay_q;
	logic [AW-1:0]                     thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= eoat_pkg::CENTER_X_RST;
			center_y_q <= eoat_pkg::CENTER_Y_RST;
			step_q     <= eoat_pkg::STEP_RST;
			decay_q    <= eoat_pkg::DECAY_RST;
			thresh_q   <= eoat_pkg::THRESH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				eoat_pkg::CFG_CENTER_X:       center_x_q <= cfg_data[CW-1:0];
				eoat_pkg::CFG_CENTER_Y:       center_y_q <= cfg_data[CW-1:0];
				eoat_pkg::CFG_STEP_SIZE:      step_q     <= cfg_data[AW-1:0];
				eoat_pkg::CFG_DECAY_SHIFT:    decay_q    <= cfg_data[eoat_pkg::SHIFT_W-1:0];
				eoat_pkg::CFG_EMIT_THRESHOLD: thresh_q   <= cfg_data[AW-1:0];
				default: ;
			endcase
		end
	end

	// event geometry
	logic [CW:0]                  dx, dy, ndx, ndy;
	logic [CW-1:0]                adx, ady, rmax;
	logic                         x_dom;
	logic [eoat_pkg::RAD_W-1:0]   rq;
	logic [eoat_pkg::WEDGE_W-1:0] wedge;

	always_comb begin
		dx    = {1'b0, x_pos} - {1'b0, center_x_q};
		dy    = {1'b0, y_pos} - {1'b0, center_y_q};
		ndx   = '0 - dx;
		ndy   = '0 - dy;
		adx   = dx[CW] ? ndx[CW-1:0] : dx[CW-1:0];
		ady   = dy[CW] ? ndy[CW-1:0] : dy[CW-1:0];
		x_dom = (adx >= ady);
		rmax  = x_dom ? adx : ady;
		rq    = rmax[CW-1] ? eoat_pkg::RAD_CAP : rmax[eoat_pkg::RAD_W:1];
		if (x_dom) begin
			wedge = dx[CW] ? eoat_pkg::WEDGE_WEST : eoat_pkg::WEDGE_E;
		end else if (dy[CW]) begin
			wedge = dx[CW] ? eoat_pkg::WEDGE_NW : eoat_pkg::WEDGE_NE;
		end else begin
			wedge = dx[CW] ? eoat_pkg::WEDGE_SW : eoat_pkg::WEDGE_SE;
		end
	end

	// per-wedge stores
	logic [AW-1:0]    act_q [NW];
	logic [SUM_W-1:0] sum_q [NW];
	logic [CNT_W-1:0] cnt_q [NW];
	logic             pol_q [NW];
	logic [POS_W-1:0] pos_q;

	logic [AW:0]      act_sum;
	logic [AW-1:0]    act_new;
	logic [SUM_W-1:0] sum_new;
	logic [CNT_W-1:0] cnt_new;

	always_comb begin
		act_sum = {1'b0, act_q[wedge]} + {1'b0, step_q};
		act_new = act_sum[AW] ? eoat_pkg::ACT_CAP : act_sum[AW-1:0];
		sum_new = sum_q[wedge] + SUM_W'(rq);
		cnt_new = cnt_q[wedge] + CNT_W'(1);
	end

	assign stat.last = (pos_q == POS_W'(BATCH_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.pick) begin
			pos_q <= '0;
		end else if (cmd.upd && !stat.last) begin
			pos_q <= pos_q + POS_W'(1);
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_wedge
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				act_q[i] <= '0;
				sum_q[i] <= '0;
				cnt_q[i] <= '0;
				pol_q[i] <= 1'b0;
			end else begin
				if (cmd.upd && (wedge == eoat_pkg::WEDGE_W'(i))) begin
					act_q[i] <= act_new;
					sum_q[i] <= sum_new;
					cnt_q[i] <= cnt_new;
					pol_q[i] <= polarity;
				end else if (cmd.leak) begin
					act_q[i] <= act_q[i] - (act_q[i] >> decay_q);
				end else if (cmd.pick) begin
					sum_q[i] <= '0;
					cnt_q[i] <= '0;
					pol_q[i] <= 1'b0;
				end
			end
		end
	end

	// argmax tree, lowest index wins ties
	cand_t leaf [NW];
	cand_t l1   [NW/2];
	cand_t l2   [NW/4];
	cand_t best;

	logic [1:0]       rsh;
	logic [SUM_W-1:0] rshift;
	logic [eoat_pkg::RAD_W-1:0] rad;

	always_comb begin
		for (int i = 0; i < NW; i++) begin
			leaf[i].idx = eoat_pkg::WEDGE_W'(i);
			leaf[i].act = act_q[i];
			leaf[i].sum = sum_q[i];
			leaf[i].cnt = cnt_q[i];
			leaf[i].pol = pol_q[i];
		end
		for (int j = 0; j < NW/2; j++) begin
			l1[j] = pick_c(leaf[2*j], leaf[2*j+1]);
		end
		for (int j = 0; j < NW/4; j++) begin
			l2[j] = pick_c(l1[2*j], l1[2*j+1]);
		end
		best = pick_c(l2[0], l2[1]);

		if (32'(best.cnt) >= 32'd3) begin
			rsh = 2'd2;
		end else if (32'(best.cnt) == 32'd2) begin
			rsh = 2'd1;
		end else begin
			rsh = 2'd0;
		end
		rshift = best.sum >> rsh;
		if (best.cnt == '0) begin
			rad = '0;
		end else if (rshift > SUM_W'(eoat_pkg::RAD_CAP)) begin
			rad = eoat_pkg::RAD_CAP;
		end else begin
			rad = rshift[eoat_pkg::RAD_W-1:0];
		end
	end

	// result register
	logic                         res_valid_q;
	logic [eoat_pkg::WEDGE_W-1:0] octant_q;
	logic [eoat_pkg::RAD_W-1:0]   radius_q;
	logic                         pol_out_q;
	logic [eoat_pkg::RAD_W-1:0]   strength_q;
	logic                         peak_q;

	assign stat.out_free = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.pick) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick) begin
			octant_q   <= best.idx;
			radius_q   <= rad;
			pol_out_q  <= best.pol;
			strength_q <= best.act[AW-1:3];
			peak_q     <= (best.act >= thresh_q);
		end
	end

	assign res_valid         = res_valid_q;
	assign res_octant        = octant_q;
	assign res_radius        = radius_q;
	assign res_ping_polarity = pol_out_q;
	assign res_strength      = strength_q;
	assign res_peak_flag     = peak_q;

endmodule

`default_nettype wire

/* design/event_octant_activity_tracker.sv */
// Top level of the event octant activity tracker: controller plus datapath.
// Depends on eoat_pkg, eoat_if, eoat_ctrl, eoat_dp.
//
//   channel  dir  word                                                  handshake
//   evt      in   x_pos, y_pos, polarity                                valid/ready
//   res      out  octant, radius, ping_polarity, strength, peak_flag    valid/ready
//   cfg      in   cfg_index, cfg_data                                   cfg_we
//
// An event that does not close a batch updates its wedge at acceptance.
// A batch-closing event runs update, leak of all counters, then argmax into the
// result register. The argmax waits while a previous result is still held unread.
// Reset loads register defaults and clears all counters at once; no clearing pass.
// Input is accepted while a result waits, up to the next batch end.
`default_nettype none

module event_octant_activity_tracker #(
	parameter int unsigned BATCH_LEN = eoat_pkg::BATCH_LEN_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	eoat_evt_if.sink                                evt,
	eoat_res_if.source                              res,
	input  wire logic                               cfg_we,
	input  wire logic [eoat_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [eoat_pkg::CFG_DATA_W-1:0]    cfg_data
);

	eoat_pkg::cmd_t  cmd;
	eoat_pkg::stat_t stat;

	eoat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	eoat_dp #(
		.BATCH_LEN (BATCH_LEN)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.x_pos             (evt.x_pos),
		.y_pos             (evt.y_pos),
		.polarity          (evt.polarity),
		.res_valid         (res.valid),
		.res_ready         (res.ready),
		.res_octant        (res.octant),
		.res_radius        (res.radius),
		.res_ping_polarity (res.ping_polarity),
		.res_strength      (res.strength),
		.res_peak_flag     (res.peak_flag)
	);

endmodule

`default_nettype wire

/* design/eoat_chk.sv */
// Port-level checker for the octant activity tracker, bound to the top level.
// Depends on eoat_pkg and event_octant_activity_tracker_defines.svh.
`default_nettype none
`include "event_octant_activity_tracker_defines.svh"

module eoat_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           evt_valid,
	input wire logic                           evt_ready,
	input wire logic                           res_valid,
	input wire logic                           res_ready,
	input wire logic [eoat_pkg::WEDGE_W-1:0]   res_octant,
	input wire logic [eoat_pkg::RAD_W-1:0]     res_radius,
	input wire logic                           res_ping_polarity,
	input wire logic [eoat_pkg::RAD_W-1:0]     res_strength,
	input wire logic                           res_peak_flag
);

	`EOAT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`EOAT_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_octant) && $stable(res_radius) && $stable(res_ping_polarity) && $stable(res_strength) && $stable(res_peak_flag), "result word changed while stalled")
	// pure north and south wedges never gain activity
	`EOAT_ASSERT_IMPL(a_no_axis_wedge, res_valid, (res_octant != eoat_pkg::WEDGE_N) && (res_octant != eoat_pkg::WEDGE_S), "north or south wedge reported")
	// leak and pick follow the closing event, so no result appears right after an accept
	`EOAT_ASSERT_IMPL(a_res_latency, $rose(res_valid), !$past(evt_valid && evt_ready), "result too soon after an event word")

endmodule

bind event_octant_activity_tracker eoat_chk u_eoat_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.evt_valid         (evt.valid),
	.evt_ready         (evt.ready),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_octant        (res.octant),
	.res_radius        (res.radius),
	.res_ping_polarity (res.ping_polarity),
	.res_strength      (res.strength),
	.res_peak_flag     (res.peak_flag)
);

`default_nettype wire

/* dv/eoat_octant_checker.sv */
`timescale 1ns / 1ps
// Checker for the event octant activity tracker: watches the event, result and
// register ports, predicts each batch result and compares it word by word.
// Depends on eoat_pkg and the eoat_evt_if / eoat_res_if interfaces.

module eoat_octant_checker #(
	parameter int unsigned BATCH_LEN = eoat_pkg::BATCH_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	eoat_evt_if                               evt,
	eoat_res_if                               res,
	input  logic                              cfg_we,
	input  logic [eoat_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [eoat_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                errors,
	output int                                pending,
	output int                                words_seen,
	output int                                events_seen
);

	typedef enum logic [2:0] {
		OCT_E, OCT_NE, OCT_N, OCT_NW, OCT_W, OCT_SW, OCT_S, OCT_SE
	} octant_t;

	typedef struct packed {
		logic [2:0] octant;
		logic [4:0] radius;
		logic       pol;
		logic [4:0] strength;
		logic       peak;
	} dominant_t;

	logic [6:0] center_x;
	logic [6:0] center_y;
	logic [7:0] step_amt;
	logic [2:0] leak_shift;
	logic [7:0] peak_level;

	logic [7:0] activity [8];
	int         rad_sum [8];
	int         hits [8];
	logic       wedge_pol [8];
	int         fill;

	dominant_t  dominant_q [$];

	function automatic void clear_batch();
		for (int i = 0; i < 8; i++) begin
			rad_sum[i] = 0;
			hits[i] = 0;
			wedge_pol[i] = 1'b0;
		end
		fill = 0;
	endfunction

	task automatic reset_tracker();
		center_x = eoat_pkg::CENTER_X_RST;
		center_y = eoat_pkg::CENTER_Y_RST;
		step_amt = eoat_pkg::STEP_RST;
		leak_shift = eoat_pkg::DECAY_RST;
		peak_level = eoat_pkg::THRESH_RST;
		for (int i = 0; i < 8; i++)
			activity[i] = 8'd0;
		clear_batch();
		dominant_q.delete();
		errors = 0;
		words_seen = 0;
		events_seen = 0;
	endtask

	function automatic void absorb_event(input logic [6:0] x, input logic [6:0] y,
		input logic pol);
		int        dx, dy, adx, ady, rq, warmed, best, top_act, sh, rad;
		octant_t   w;
		dominant_t d;

		dx = int'(x) - int'(center_x);
		dy = int'(y) - int'(center_y);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		if (adx >= ady)
			w = (dx >= 0) ? OCT_E : OCT_W;
		else if (dy < 0)
			w = (dx >= 0) ? OCT_NE : OCT_NW;
		else
			w = (dx >= 0) ? OCT_SE : OCT_SW;
		rq = ((adx >= ady) ? adx : ady) >> 1;
		if (rq > 31)
			rq = 31;

		warmed = int'(activity[w]) + int'(step_amt);
		activity[w] = (warmed > 255) ? 8'd255 : 8'(warmed);
		rad_sum[w] += rq;
		hits[w] += 1;
		wedge_pol[w] = pol;
		fill++;
		if (fill < BATCH_LEN)
			return;

		for (int i = 0; i < 8; i++)
			activity[i] = activity[i] - (activity[i] >> leak_shift);

		best = 0;
		top_act = 0;
		for (int i = 0; i < 8; i++) begin
			if (int'(activity[i]) > top_act) begin
				top_act = int'(activity[i]);
				best = i;
			end
		end

		rad = 0;
		if (hits[best] > 0) begin
			sh = (hits[best] >= 3) ? 2 : ((hits[best] == 2) ? 1 : 0);
			rad = rad_sum[best] >> sh;
			if (rad > 31)
				rad = 31;
		end

		d.octant = 3'(best);
		d.radius = 5'(rad);
		d.pol = wedge_pol[best];
		d.strength = 5'(top_act >> 3);
		d.peak = (top_act >= int'(peak_level));
		dominant_q.push_back(d);
		clear_batch();
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		if (errors < 40)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic check_word();
		dominant_t want;
		if (dominant_q.size() == 0) begin
			flag_mismatch("result word with none pending (octant)", int'(res.octant), -1);
			return;
		end
		want = dominant_q.pop_front();
		words_seen++;
		if (res.octant !== want.octant)
			flag_mismatch("octant", int'(res.octant), int'(want.octant));
		if (res.radius !== want.radius)
			flag_mismatch("radius", int'(res.radius), int'(want.radius));
		if (res.ping_polarity !== want.pol)
			flag_mismatch("ping_polarity", int'(res.ping_polarity), int'(want.pol));
		if (res.strength !== want.strength)
			flag_mismatch("strength", int'(res.strength), int'(want.strength));
		if (res.peak_flag !== want.peak)
			flag_mismatch("peak_flag", int'(res.peak_flag), int'(want.peak));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_tracker();
		end else begin
			if (res.valid && res.ready)
				check_word();
			if (evt.valid && evt.ready) begin
				events_seen++;
				absorb_event(evt.x_pos, evt.y_pos, evt.polarity);
			end
			if (cfg_we) begin
				case (cfg_index)
					eoat_pkg::CFG_CENTER_X:       center_x = cfg_data[6:0];
					eoat_pkg::CFG_CENTER_Y:       center_y = cfg_data[6:0];
					eoat_pkg::CFG_STEP_SIZE:      step_amt = cfg_data;
					eoat_pkg::CFG_DECAY_SHIFT:    leak_shift = cfg_data[2:0];
					eoat_pkg::CFG_EMIT_THRESHOLD: peak_level = cfg_data;
					default: ;
				endcase
			end
		end
		pending = dominant_q.size();
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the octant activity tracker testbench: clock, reset, register setup,
// directed and random event stimulus, result-side stalls and the verdict.
// Depends on eoat_pkg, the channel interfaces, the tracker and eoat_octant_checker.

module tb_top;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          PHASE_ITEMS = 256;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [eoat_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [eoat_pkg::CFG_DATA_W-1:0] cfg_data;

	int errors, pending, words_seen, events_seen;
	int send_idle, recv_stall;
	int settings_used;
	int hot_x, hot_y, cur_cx, cur_cy;
	int unsigned cycles = 0;

	eoat_evt_if evt_ch ();
	eoat_res_if res_ch ();

	event_octant_activity_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	eoat_octant_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (evt_ch),
		.res         (res_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending),
		.words_seen  (words_seen),
		.events_seen (events_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words pending", cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		res_ch.ready <= ($urandom_range(99) < recv_stall) ? 1'b0 : 1'b1;

	task automatic send_event(input logic [6:0] x, input logic [6:0] y, input logic p);
		if ($urandom_range(99) < send_idle) begin
			evt_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.x_pos <= x;
		evt_ch.y_pos <= y;
		evt_ch.polarity <= p;
		do @(posedge clk); while (!evt_ch.ready);
	endtask

	// drop valid, wait for every expected word, then let the block go quiet
	task automatic settle_block();
		evt_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_settings(input logic [6:0] cx, input logic [6:0] cy,
		input logic [7:0] stp, input logic [2:0] sh, input logic [7:0] thr);
		cfg_we <= 1'b1;
		cfg_index <= eoat_pkg::CFG_CENTER_X;
		cfg_data <= {1'b0, cx};
		@(posedge clk);
		cfg_index <= eoat_pkg::CFG_CENTER_Y;
		cfg_data <= {1'b0, cy};
		@(posedge clk);
		cfg_index <= eoat_pkg::CFG_STEP_SIZE;
		cfg_data <= stp;
		@(posedge clk);
		cfg_index <= eoat_pkg::CFG_DECAY_SHIFT;
		cfg_data <= {5'd0, sh};
		@(posedge clk);
		cfg_index <= eoat_pkg::CFG_EMIT_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		// unused index, must be ignored
		cfg_index <= 3'(eoat_pkg::CFG_EMIT_THRESHOLD) + 3'($urandom_range(1, 3));
		cfg_data <= 8'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cx = int'(cx);
		cur_cy = int'(cy);
		settings_used++;
	endtask

	task automatic set_idle_mode(input int mode);
		case (mode)
			1: begin send_idle = 57; recv_stall = 0; end
			2: begin send_idle = 0; recv_stall = 57; end
			3: begin send_idle = 21; recv_stall = 21; end
			default: begin send_idle = 0; recv_stall = 0; end
		endcase
	endtask

	// mostly clustered around a moving hot spot so one wedge builds up
	task automatic random_event();
		int r, x, y;
		r = $urandom_range(99);
		if (r < 60) begin
			x = hot_x + int'($urandom_range(12)) - 6;
			y = hot_y + int'($urandom_range(12)) - 6;
		end else if (r < 85) begin
			x = int'($urandom_range(127));
			y = int'($urandom_range(127));
		end else begin
			x = ($urandom_range(2) == 0) ? cur_cx : ($urandom_range(1) ? 127 : 0);
			y = ($urandom_range(2) == 0) ? cur_cy : ($urandom_range(1) ? 127 : 0);
		end
		if (x < 0) x = 0;
		if (x > 127) x = 127;
		if (y < 0) y = 0;
		if (y > 127) y = 127;
		send_event(7'(x), 7'(y), 1'($urandom_range(1)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = eoat_pkg::CFG_CENTER_X;
		cfg_data = 8'd0;
		evt_ch.valid = 1'b0;
		evt_ch.x_pos = 7'd0;
		evt_ch.y_pos = 7'd0;
		evt_ch.polarity = 1'b0;
		res_ch.ready = 1'b0;
		set_idle_mode(0);
		settings_used = 1;
		cur_cx = int'(eoat_pkg::CENTER_X_RST);
		cur_cy = int'(eoat_pkg::CENTER_Y_RST);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: centre, every wedge side, ties, clamped radius
		send_event(7'd63, 7'd56, 1'b0);
		send_event(7'd127, 7'd56, 1'b1);
		send_event(7'd0, 7'd56, 1'b0);
		send_event(7'd63, 7'd0, 1'b1);
		send_event(7'd62, 7'd127, 1'b1);
		send_event(7'd64, 7'd127, 1'b0);
		send_event(7'd62, 7'd0, 1'b1);
		send_event(7'd73, 7'd66, 1'b1);
		send_event(7'd53, 7'd46, 1'b0);
		send_event(7'd127, 7'd127, 1'b1);
		send_event(7'd0, 7'd0, 1'b0);
		send_event(7'd127, 7'd0, 1'b1);
		send_event(7'd0, 7'd127, 1'b1);
		send_event(7'd70, 7'd10, 1'b0);
		send_event(7'd65, 7'd20, 1'b1);
		send_event(7'd66, 7'd30, 1'b0);
		settle_block();

		// far corner centre, saturating step, slowest leak, top threshold
		load_settings(7'd127, 7'd127, 8'd255, 3'd7, 8'd255);
		send_event(7'd127, 7'd127, 1'b1);
		send_event(7'd0, 7'd0, 1'b0);
		send_event(7'd127, 7'd0, 1'b1);
		send_event(7'd0, 7'd127, 1'b0);
		send_event(7'd126, 7'd0, 1'b1);
		send_event(7'd0, 7'd1, 1'b1);
		send_event(7'd127, 7'd126, 1'b0);
		send_event(7'd100, 7'd0, 1'b1);
		settle_block();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_settings(7'($urandom_range(127)), 7'($urandom_range(127)),
					8'($urandom_range(1, 80)), 3'($urandom_range(1, 7)), 8'($urandom));
				1: load_settings(7'd127, 7'd127, 8'd0, 3'd0, 8'd0);
				2: load_settings(7'd0, 7'd0, 8'd255, 3'd7, 8'd255);
				3: load_settings(7'($urandom), 7'($urandom), 8'($urandom), 3'($urandom),
					8'($urandom));
				4: load_settings(7'd0, 7'd127, 8'($urandom_range(1, 255)), 3'($urandom),
					8'd128);
				default: load_settings(7'($urandom), 7'($urandom), 8'($urandom_range(1, 40)),
					3'($urandom_range(1, 7)), 8'($urandom));
			endcase
			set_idle_mode(ph % 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					hot_x = int'($urandom_range(127));
					hot_y = int'($urandom_range(127));
				end
				random_event();
			end
			settle_block();
		end

		$display("Covered %0d events and %0d result words under %0d register settings,",
			events_seen, words_seen, settings_used);
		$display("with free-running, sender-idle, receiver-stall and mixed idle phases.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
